/* hdl/srsw_pkg.sv */
`default_nettype none

package srsw_pkg;

   // Defaults for the top-level parameters
   localparam int SEQ_COUNT_DEF   = 16;
   localparam int PENDING_MAX_DEF = 255;

   // Field widths
   localparam int FUNC_W    = 2;
   localparam int SEQ_OUT_W = 4;
   localparam int WIN_W     = 4;
   localparam int TMO_W     = 16;

   // Configuration port
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_IDX_BIT = 2;
   localparam logic CSR_IDX_WINDOW  = 1'b0;
   localparam logic CSR_IDX_TIMEOUT = 1'b1;
   localparam logic [WIN_W-1:0] WINDOW_RESET  = 4'd8;
   localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd1000;

   // Input function codes
   localparam logic [FUNC_W-1:0] FUNC_REQ  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ACK  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd2;

   // Queue depths (powers of two, pointers wrap on their own)
   localparam int CMD_QUEUE_DEPTH = 2;
   localparam int CMD_PTR_W       = $clog2(CMD_QUEUE_DEPTH);
   localparam int CMD_CNT_W       = CMD_PTR_W + 1;
   localparam int RSP_QUEUE_DEPTH = 2;
   localparam int RSP_PTR_W       = $clog2(RSP_QUEUE_DEPTH);
   localparam int RSP_CNT_W       = RSP_PTR_W + 1;

   typedef enum logic [1:0] {
      CMD_REQ,
      CMD_ACK,
      CMD_TICK
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type           kind;
      logic [SEQ_OUT_W-1:0]   ack_seq;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_head_type;

   typedef struct packed {
      logic [SEQ_OUT_W-1:0] send_seq;
      logic                 is_resend;
      logic                 request_dropped;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      logic    push;
      rsp_type rsp;
   } rsp_push_type;

   typedef enum logic [1:0] {
      SLOT_EMPTY,
      SLOT_UNACKED,
      SLOT_ACKED
   } slot_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REQ,
      ST_ACK,
      ST_SLIDE,
      ST_FILL,
      ST_TICK_RD,
      ST_TICK_WR,
      ST_DONE
   } eng_state_type;

endpackage

`default_nettype wire

/* hdl/selective_repeat_sender_window.sv */
`default_nettype none

// Channel    Ports                                      Handshake
// --------   ----------------------------------------   ------------------------------
// request    req_func, req_ack_seq, req_ack_corrupt      push & !full
// result     rsp_send_seq, rsp_is_resend,                pop & !empty
//            rsp_request_dropped, rsp_last
// config     paddr, pwdata, prdata                       psel & penable & pwrite & pready
//
// In the engine a request goes through REQ, then FILL, which sends the packets one by one,
// and DONE. An ack goes through ACK, then SLIDE past acked slots when it lands on the base,
// then FILL and DONE. A tick reads and then updates each in-flight countdown through the
// registered read of the countdown memory. Corrupt acks and unknown codes never reach the engine.
// Reset is synchronous; slot status clears at once, so no clearing pass is needed.
// A two-entry command queue keeps taking items while the engine works, and a two-entry
// result queue plus one held result let the engine run on while pop is low.

module selective_repeat_sender_window #(
   parameter int SEQ_COUNT   = srsw_pkg::SEQ_COUNT_DEF,
   parameter int PENDING_MAX = srsw_pkg::PENDING_MAX_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              push,
   output      logic                              full,
   input  wire logic [srsw_pkg::FUNC_W-1:0]       req_func,
   input  wire logic [srsw_pkg::SEQ_OUT_W-1:0]    req_ack_seq,
   input  wire logic                              req_ack_corrupt,
   // result channel
   output      logic                              empty,
   input  wire logic                              pop,
   output      logic [srsw_pkg::SEQ_OUT_W-1:0]    rsp_send_seq,
   output      logic                              rsp_is_resend,
   output      logic                              rsp_request_dropped,
   output      logic                              rsp_last,
   // configuration port
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [srsw_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [srsw_pkg::CSR_DATA_W-1:0]   pwdata,
   output      logic [srsw_pkg::CSR_DATA_W-1:0]   prdata,
   output      logic                              pready
);

   logic [srsw_pkg::WIN_W-1:0]    win_limit_ff, win_limit_in;
   logic [srsw_pkg::TMO_W-1:0]    timeout_ticks_ff, timeout_ticks_in;
   logic                          csr_wr;
   logic                          csr_idx;

   srsw_pkg::cmd_head_type        cmd_head;
   logic                          cmd_pop;
   srsw_pkg::rsp_push_type        rsp_wr;
   logic                          rsp_full;

   // ---------------------------------------------------------------------------------
   // Configuration registers: always ready, write lands on the access cycle.
   // Register select is the word bit of the address; low byte bits are ignored.
   // ---------------------------------------------------------------------------------
   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite & pready;
   assign csr_idx = paddr[srsw_pkg::CSR_IDX_BIT];

   always_comb begin
      win_limit_in     = win_limit_ff;
      timeout_ticks_in = timeout_ticks_ff;
      if (csr_wr) begin
         if (csr_idx == srsw_pkg::CSR_IDX_WINDOW) begin
            win_limit_in = pwdata[srsw_pkg::WIN_W-1:0];
         end else begin
            timeout_ticks_in = pwdata[srsw_pkg::TMO_W-1:0];
         end
      end
   end

   // Read back the selected register, zero-extended
   always_comb begin
      case (csr_idx)
         srsw_pkg::CSR_IDX_WINDOW:  prdata = srsw_pkg::CSR_DATA_W'(win_limit_ff);
         srsw_pkg::CSR_IDX_TIMEOUT: prdata = srsw_pkg::CSR_DATA_W'(timeout_ticks_ff);
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_limit_ff     <= srsw_pkg::WINDOW_RESET;
         timeout_ticks_ff <= srsw_pkg::TIMEOUT_RESET;
      end else begin
         win_limit_ff     <= win_limit_in;
         timeout_ticks_ff <= timeout_ticks_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // Front: take each transfer, drop corrupt acks and unknown codes, queue the rest.
   // ---------------------------------------------------------------------------------
   srsw_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_func        (req_func),
      .req_ack_seq     (req_ack_seq),
      .req_ack_corrupt (req_ack_corrupt),
      .cmd_head        (cmd_head),
      .cmd_pop         (cmd_pop)
   );

   // ---------------------------------------------------------------------------------
   // Engine: walk the window one slot per step, mark acks, slide the base, fill
   // from pending and count down on ticks. Each item's results leave in order, the
   // final one marked last.
   // ---------------------------------------------------------------------------------
   srsw_engine #(
      .SEQ_COUNT   (SEQ_COUNT),
      .PENDING_MAX (PENDING_MAX)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .win_limit     (win_limit_ff),
      .timeout_ticks (timeout_ticks_ff),
      .cmd_head      (cmd_head),
      .cmd_pop       (cmd_pop),
      .rsp_full      (rsp_full),
      .rsp_wr        (rsp_wr)
   );

   // ---------------------------------------------------------------------------------
   // Result queue: hold results until the consumer pops them.
   // ---------------------------------------------------------------------------------
   srsw_rsp_queue u_rsp_queue (
      .clock               (clock),
      .reset               (reset),
      .rsp_wr              (rsp_wr),
      .rsp_full            (rsp_full),
      .empty               (empty),
      .pop                 (pop),
      .rsp_send_seq        (rsp_send_seq),
      .rsp_is_resend       (rsp_is_resend),
      .rsp_request_dropped (rsp_request_dropped),
      .rsp_last            (rsp_last)
   );

endmodule

`default_nettype wire

/* hdl/srsw_front.sv */
`default_nettype none

module srsw_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             push,
   output      logic                             full,
   input  wire logic [srsw_pkg::FUNC_W-1:0]      req_func,
   input  wire logic [srsw_pkg::SEQ_OUT_W-1:0]   req_ack_seq,
   input  wire logic                             req_ack_corrupt,
   output      srsw_pkg::cmd_head_type           cmd_head,
   input  wire logic                             cmd_pop
);

   srsw_pkg::cmd_type                     queue_ff [srsw_pkg::CMD_QUEUE_DEPTH];
   logic [srsw_pkg::CMD_PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [srsw_pkg::CMD_PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [srsw_pkg::CMD_CNT_W-1:0]        count_ff, count_in;
   srsw_pkg::cmd_type                     cmd;
   logic                                  keep;
   logic                                  wr;
   logic                                  rd;

   // Classify: corrupt acks and unknown codes are taken and dropped here
   always_comb begin
      keep        = 1'b0;
      cmd.kind    = srsw_pkg::CMD_REQ;
      cmd.ack_seq = req_ack_seq;
      case (req_func)
         srsw_pkg::FUNC_REQ: begin
            keep     = 1'b1;
            cmd.kind = srsw_pkg::CMD_REQ;
         end
         srsw_pkg::FUNC_ACK: begin
            keep     = ~req_ack_corrupt;
            cmd.kind = srsw_pkg::CMD_ACK;
         end
         srsw_pkg::FUNC_TICK: begin
            keep     = 1'b1;
            cmd.kind = srsw_pkg::CMD_TICK;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign full           = (count_ff == srsw_pkg::CMD_CNT_W'(srsw_pkg::CMD_QUEUE_DEPTH));
   assign cmd_head.valid = (count_ff != '0);
   assign cmd_head.cmd   = queue_ff[rd_ptr_ff];
   assign wr             = push & ~full & keep;
   assign rd             = cmd_pop & cmd_head.valid;

   always_comb begin
      wr_ptr_in = wr ? srsw_pkg::CMD_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = rd ? srsw_pkg::CMD_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      case ({wr, rd})
         2'b10:   count_in = srsw_pkg::CMD_CNT_W'(count_ff + 1'b1);
         2'b01:   count_in = srsw_pkg::CMD_CNT_W'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         queue_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

`default_nettype wire

/* hdl/srsw_rsp_queue.sv */
`default_nettype none

module srsw_rsp_queue (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire srsw_pkg::rsp_push_type           rsp_wr,
   output      logic                             rsp_full,
   output      logic                             empty,
   input  wire logic                             pop,
   output      logic [srsw_pkg::SEQ_OUT_W-1:0]   rsp_send_seq,
   output      logic                             rsp_is_resend,
   output      logic                             rsp_request_dropped,
   output      logic                             rsp_last
);

   srsw_pkg::rsp_type                     queue_ff [srsw_pkg::RSP_QUEUE_DEPTH];
   logic [srsw_pkg::RSP_PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [srsw_pkg::RSP_PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [srsw_pkg::RSP_CNT_W-1:0]        count_ff, count_in;
   srsw_pkg::rsp_type                     head;
   logic                                  wr;
   logic                                  rd;

   assign rsp_full = (count_ff == srsw_pkg::RSP_CNT_W'(srsw_pkg::RSP_QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign wr       = rsp_wr.push & ~rsp_full;
   assign rd       = pop & ~empty;
   assign head     = queue_ff[rd_ptr_ff];

   assign rsp_send_seq        = head.send_seq;
   assign rsp_is_resend       = head.is_resend;
   assign rsp_request_dropped = head.request_dropped;
   assign rsp_last            = head.last;

   always_comb begin
      wr_ptr_in = wr ? srsw_pkg::RSP_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = rd ? srsw_pkg::RSP_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      case ({wr, rd})
         2'b10:   count_in = srsw_pkg::RSP_CNT_W'(count_ff + 1'b1);
         2'b01:   count_in = srsw_pkg::RSP_CNT_W'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         queue_ff[wr_ptr_ff] <= rsp_wr.rsp;
      end
   end

endmodule

`default_nettype wire

/* hdl/srsw_engine.sv */
`default_nettype none

module srsw_engine #(
   parameter int SEQ_COUNT   = srsw_pkg::SEQ_COUNT_DEF,
   parameter int PENDING_MAX = srsw_pkg::PENDING_MAX_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [srsw_pkg::WIN_W-1:0]       win_limit,
   input  wire logic [srsw_pkg::TMO_W-1:0]       timeout_ticks,
   input  wire srsw_pkg::cmd_head_type           cmd_head,
   output      logic                             cmd_pop,
   input  wire logic                             rsp_full,
   output      srsw_pkg::rsp_push_type           rsp_wr
);

   localparam int SEQ_W   = $clog2(SEQ_COUNT);
   localparam int PEND_W  = $clog2(PENDING_MAX + 1);
   localparam int CAP_INT = (SEQ_COUNT - 1 < 15) ? (SEQ_COUNT - 1) : 15;
   localparam logic [srsw_pkg::WIN_W-1:0] WIN_CAP  = srsw_pkg::WIN_W'(CAP_INT);
   localparam logic [SEQ_W-1:0]           LAST_SEQ = SEQ_W'(SEQ_COUNT - 1);
   localparam logic [SEQ_W:0]             SEQ_MOD  = (SEQ_W + 1)'(SEQ_COUNT);
   localparam logic [PEND_W-1:0]          PEND_FULL = PEND_W'(PENDING_MAX);

   srsw_pkg::eng_state_type               state_ff, state_in;
   logic [SEQ_W-1:0]                      base_ff, base_in;
   logic [SEQ_W-1:0]                      next_ff, next_in;
   logic [srsw_pkg::WIN_W-1:0]            inflight_ff, inflight_in;
   logic [PEND_W-1:0]                     pending_ff, pending_in;
   logic [srsw_pkg::SEQ_OUT_W-1:0]        ack_ff, ack_in;
   logic [SEQ_W-1:0]                      scan_ff, scan_in;
   logic [srsw_pkg::WIN_W-1:0]            scan_cnt_ff, scan_cnt_in;
   srsw_pkg::rsp_type                     held_ff, held_in;
   logic                                  held_valid_ff, held_valid_in;

   srsw_pkg::slot_status_type             status_ff [SEQ_COUNT];
   logic [srsw_pkg::TMO_W-1:0]            cd_mem [SEQ_COUNT];
   logic [srsw_pkg::TMO_W-1:0]            cd_rd_ff;

   logic [SEQ_W-1:0]                      slot_rd_idx;
   srsw_pkg::slot_status_type             slot_rd;
   logic                                  slot_we;
   logic [SEQ_W-1:0]                      slot_wa;
   srsw_pkg::slot_status_type             slot_wd;
   logic                                  cd_we;
   logic [SEQ_W-1:0]                      cd_wa;
   logic [srsw_pkg::TMO_W-1:0]            cd_wd;

   logic [srsw_pkg::WIN_W-1:0]            eff_win;
   logic                                  can_fill;
   logic                                  emit_ok;
   logic                                  pend_full;
   logic                                  ack_in_range;
   logic [SEQ_W-1:0]                      ack_idx;
   logic [SEQ_W:0]                        ack_off;
   logic                                  ack_hit;
   logic                                  slide_go;
   logic                                  tick_unacked;
   logic                                  tick_expire;
   logic                                  tick_last;
   logic                                  tick_adv;
   logic                                  emit;
   srsw_pkg::rsp_type                     emit_rsp;

   function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
      seq_inc = (s == LAST_SEQ) ? '0 : SEQ_W'(s + 1'b1);
   endfunction

   // Shared conditions
   assign eff_win   = (win_limit > WIN_CAP) ? WIN_CAP : win_limit;
   assign can_fill  = (inflight_ff < eff_win) && (pending_ff != '0);
   assign emit_ok   = ~held_valid_ff | ~rsp_full;
   assign pend_full = (pending_ff == PEND_FULL);

   assign ack_in_range = (int'(ack_ff) < SEQ_COUNT);
   assign ack_idx      = SEQ_W'(ack_ff);
   assign ack_off      = (ack_idx >= base_ff)
                         ? (SEQ_W + 1)'({1'b0, ack_idx} - {1'b0, base_ff})
                         : (SEQ_W + 1)'({1'b0, ack_idx} + SEQ_MOD - {1'b0, base_ff});

   // One status read port, steered by state
   always_comb begin
      case (state_ff)
         srsw_pkg::ST_ACK:     slot_rd_idx = ack_idx;
         srsw_pkg::ST_SLIDE:   slot_rd_idx = base_ff;
         srsw_pkg::ST_TICK_WR: slot_rd_idx = scan_ff;
         default:              slot_rd_idx = next_ff;
      endcase
   end
   assign slot_rd = status_ff[slot_rd_idx];

   assign ack_hit      = ack_in_range && (int'(ack_off) < int'(inflight_ff))
                         && (slot_rd == srsw_pkg::SLOT_UNACKED);
   assign slide_go     = (inflight_ff != '0) && (slot_rd == srsw_pkg::SLOT_ACKED);
   assign tick_unacked = (slot_rd == srsw_pkg::SLOT_UNACKED);
   assign tick_expire  = tick_unacked && (cd_rd_ff <= srsw_pkg::TMO_W'(1));
   assign tick_last    = (srsw_pkg::WIN_W'(scan_cnt_ff + 1'b1) == inflight_ff);
   assign tick_adv     = ~tick_expire | emit_ok;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srsw_pkg::ST_IDLE: begin
            if (cmd_head.valid) begin
               case (cmd_head.cmd.kind)
                  srsw_pkg::CMD_REQ:  state_in = srsw_pkg::ST_REQ;
                  srsw_pkg::CMD_ACK:  state_in = srsw_pkg::ST_ACK;
                  srsw_pkg::CMD_TICK: state_in = (inflight_ff == '0) ? srsw_pkg::ST_DONE
                                                                     : srsw_pkg::ST_TICK_RD;
                  default:            state_in = srsw_pkg::ST_DONE;
               endcase
            end
         end
         srsw_pkg::ST_REQ: begin
            if (!pend_full || emit_ok) begin
               state_in = srsw_pkg::ST_FILL;
            end
         end
         srsw_pkg::ST_ACK: begin
            if (ack_hit && ack_off == '0) begin
               state_in = srsw_pkg::ST_SLIDE;
            end else begin
               state_in = srsw_pkg::ST_FILL;
            end
         end
         srsw_pkg::ST_SLIDE: begin
            if (!slide_go) begin
               state_in = srsw_pkg::ST_FILL;
            end
         end
         srsw_pkg::ST_FILL: begin
            if (!can_fill) begin
               state_in = srsw_pkg::ST_DONE;
            end
         end
         srsw_pkg::ST_TICK_RD: begin
            state_in = srsw_pkg::ST_TICK_WR;
         end
         srsw_pkg::ST_TICK_WR: begin
            if (tick_adv) begin
               state_in = tick_last ? srsw_pkg::ST_DONE : srsw_pkg::ST_TICK_RD;
            end
         end
         srsw_pkg::ST_DONE: begin
            if (!held_valid_ff || !rsp_full) begin
               state_in = srsw_pkg::ST_IDLE;
            end
         end
         default: state_in = srsw_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      base_in       = base_ff;
      next_in       = next_ff;
      inflight_in   = inflight_ff;
      pending_in    = pending_ff;
      ack_in        = ack_ff;
      scan_in       = scan_ff;
      scan_cnt_in   = scan_cnt_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      cmd_pop       = 1'b0;
      slot_we       = 1'b0;
      slot_wa       = next_ff;
      slot_wd       = srsw_pkg::SLOT_UNACKED;
      cd_we         = 1'b0;
      cd_wa         = next_ff;
      cd_wd         = timeout_ticks;
      emit          = 1'b0;
      emit_rsp      = '0;
      rsp_wr.push   = 1'b0;
      rsp_wr.rsp    = held_ff;

      case (state_ff)
         srsw_pkg::ST_IDLE: begin
            if (cmd_head.valid) begin
               cmd_pop     = 1'b1;
               ack_in      = cmd_head.cmd.ack_seq;
               scan_in     = base_ff;
               scan_cnt_in = '0;
            end
         end
         srsw_pkg::ST_REQ: begin
            if (pend_full) begin
               emit                     = emit_ok;
               emit_rsp.request_dropped = 1'b1;
            end else begin
               pending_in = PEND_W'(pending_ff + 1'b1);
            end
         end
         srsw_pkg::ST_ACK: begin
            if (ack_hit) begin
               slot_we = 1'b1;
               slot_wa = ack_idx;
               slot_wd = srsw_pkg::SLOT_ACKED;
            end
         end
         srsw_pkg::ST_SLIDE: begin
            if (slide_go) begin
               slot_we     = 1'b1;
               slot_wa     = base_ff;
               slot_wd     = srsw_pkg::SLOT_EMPTY;
               base_in     = seq_inc(base_ff);
               inflight_in = srsw_pkg::WIN_W'(inflight_ff - 1'b1);
            end
         end
         srsw_pkg::ST_FILL: begin
            if (can_fill && emit_ok) begin
               slot_we           = 1'b1;
               cd_we             = 1'b1;
               emit              = 1'b1;
               emit_rsp.send_seq = srsw_pkg::SEQ_OUT_W'(next_ff);
               next_in           = seq_inc(next_ff);
               inflight_in       = srsw_pkg::WIN_W'(inflight_ff + 1'b1);
               pending_in        = PEND_W'(pending_ff - 1'b1);
            end
         end
         srsw_pkg::ST_TICK_WR: begin
            cd_wa = scan_ff;
            if (tick_expire) begin
               if (emit_ok) begin
                  cd_we              = 1'b1;
                  emit               = 1'b1;
                  emit_rsp.send_seq  = srsw_pkg::SEQ_OUT_W'(scan_ff);
                  emit_rsp.is_resend = 1'b1;
               end
            end else if (tick_unacked) begin
               cd_we = 1'b1;
               cd_wd = srsw_pkg::TMO_W'(cd_rd_ff - 1'b1);
            end
            if (tick_adv) begin
               scan_in     = seq_inc(scan_ff);
               scan_cnt_in = srsw_pkg::WIN_W'(scan_cnt_ff + 1'b1);
            end
         end
         srsw_pkg::ST_DONE: begin
            // Flush the held result with the end-of-item marker
            if (held_valid_ff && !rsp_full) begin
               rsp_wr.push     = 1'b1;
               rsp_wr.rsp.last = 1'b1;
               held_valid_in   = 1'b0;
            end
         end
         default: begin
         end
      endcase

      // A new result pushes the held one out, not marked last
      if (emit) begin
         rsp_wr.push     = held_valid_ff;
         rsp_wr.rsp.last = 1'b0;
         held_in         = emit_rsp;
         held_valid_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= srsw_pkg::ST_IDLE;
         base_ff       <= '0;
         next_ff       <= '0;
         inflight_ff   <= '0;
         pending_ff    <= '0;
         scan_cnt_ff   <= '0;
         held_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         base_ff       <= base_in;
         next_ff       <= next_in;
         inflight_ff   <= inflight_in;
         pending_ff    <= pending_in;
         scan_cnt_ff   <= scan_cnt_in;
         held_valid_ff <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ack_ff  <= ack_in;
      scan_ff <= scan_in;
      held_ff <= held_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SEQ_COUNT; i++) begin
            status_ff[i] <= srsw_pkg::SLOT_EMPTY;
         end
      end else if (slot_we) begin
         status_ff[slot_wa] <= slot_wd;
      end
   end

   // Countdown store: one write, one registered read at the scan slot
   always_ff @(posedge clock) begin
      if (cd_we) begin
         cd_mem[cd_wa] <= cd_wd;
      end
      cd_rd_ff <= cd_mem[scan_ff];
   end

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      rsp_wr.push |-> !rsp_full)
      else $error("result pushed into a full queue");

   a_idle_flushed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == srsw_pkg::ST_IDLE) |-> !held_valid_ff)
      else $error("result left behind at end of item");

   a_inflight_cap: assert property (@(posedge clock) disable iff (reset)
      int'(inflight_ff) <= CAP_INT)
      else $error("in-flight count above window cap");

   a_pending_cap: assert property (@(posedge clock) disable iff (reset)
      int'(pending_ff) <= PENDING_MAX)
      else $error("pending count above limit");

   a_next_tracks: assert property (@(posedge clock) disable iff (reset)
      ((int'(base_ff) + int'(inflight_ff)) % SEQ_COUNT) == int'(next_ff))
      else $error("next sequence out of step with base and in-flight count");

endmodule

`default_nettype wire
